[hw/rtl/mss_pkg.sv]
// Package for the masked SAD template search block.
// Holds request codes, payload structs, states and store geometry.
// Depends on nothing.
package mss_pkg;

  localparam int TmplAw = 12;
  localparam int SrcAw  = 14;

  typedef enum logic [1:0] {
    REQ_TMPL   = 2'd0,
    REQ_SRC    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_TMPL_W = 3'd2,
    CFG_TMPL_H = 3'd3,
    CFG_X0     = 3'd4,
    CFG_X1     = 3'd5,
    CFG_Y0     = 3'd6,
    CFG_Y1     = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_PIX,
    ST_DRAIN,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        counted;
  } in_item_t;

  typedef struct packed {
    logic [6:0] best_x;
    logic [6:0] best_y;
    logic [9:0] difference;
    logic       found;
  } out_item_t;

  typedef struct packed {
    logic [7:0] src_width;
    logic [7:0] src_height;
    logic [6:0] tmpl_width;
    logic [6:0] tmpl_height;
    logic [6:0] x_start;
    logic [7:0] x_end;
    logic [6:0] y_start;
    logic [7:0] y_end;
  } cfg_t;

  function automatic logic [9:0] absd(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {2'b0, d};
  endfunction

  function automatic logic [9:0] rgb_sad(input logic [23:0] p, input logic [23:0] q);
    return absd(p[23:16], q[23:16]) + absd(p[15:8], q[15:8]) + absd(p[7:0], q[7:0]);
  endfunction

endpackage

[hw/rtl/mss_mem.sv]
// Synchronous memory with one write port and one registered read port.
// Generic; depends on nothing.
module mss_mem #(
  parameter int Aw = 12,
  parameter int Dw = 25
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] waddr,
  input  logic [Dw-1:0] wdata,
  input  logic [Aw-1:0] raddr,
  output logic [Dw-1:0] rdata
);
  logic [Dw-1:0] mem [2**Aw];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/mss_div.sv]
// Restoring divider, one quotient bit per cycle, for sum over template area.
// Depends on mss_pkg.
module mss_div
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [13:0] divisor,
  output logic        busy,
  output logic [23:0] quotient
);
  logic [4:0]  cnt;
  logic [23:0] rem_q;
  logic [13:0] part;
  logic [13:0] part_next;
  logic [14:0] trial;
  logic [14:0] diff;
  logic        ge;

  assign trial = {part, rem_q[23]};
  assign ge = (trial >= {1'b0, divisor});
  assign diff = trial - {1'b0, divisor};
  assign part_next = ge ? diff[13:0] : trial[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 5'd24;
      rem_q    <= dividend;
      part     <= '0;
      quotient <= '0;
    end else if (busy) begin
      part     <= part_next;
      rem_q    <= {rem_q[22:0], 1'b0};
      quotient <= {quotient[22:0], ge};
      cnt      <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

[hw/rtl/masked_sad_template_search.sv]
// Top level of the masked SAD template search: stores, scan sequencer, compare.
// Depends on mss_pkg, mss_mem and mss_div.
//
// channel   direction  handshake                payload
// in        request    in_valid / in_ready      in_item_t
// out       result     out_valid / out_ready    out_item_t
// cfg       write      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A search scans each position, reading one source pixel per cycle, then runs
// the area division and registers the result. An empty search skips the scan
// and the division.
// Reset is synchronous and clears control state; the stores are not cleared.
// A result waits in its output register while new requests are taken; a later
// result holds the sequencer until the earlier one is accepted.
module masked_sad_template_search
  import mss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  cfg_t   cfg;
  state_t state, state_next;

  logic [7:0]  px, py;
  logic [6:0]  mx, my;
  logic [11:0] trow;
  logic [13:0] srow;
  logic [23:0] sum, sumf, best;
  logic        have;
  logic [6:0]  bx, by;
  logic        vld1;
  logic        msk1;
  logic        mskf1;
  logic        div_start, div_busy;
  logic [23:0] quo;

  logic [7:0]  xlim_w, ylim_w;
  logic signed [8:0] xlim, ylim;
  logic [11:0] ta, fa;
  logic [13:0] sa;
  logic [24:0] t_rd, f_rd;
  logic [23:0] s_rd;
  logic        accept_in;
  logic        out_load;
  logic        last_mx, last_my, last_x, last_y;
  logic [23:0] cand;
  logic        take_s;

  assign xlim = $signed({1'b0, cfg.x_end}) - $signed({2'b0, cfg.tmpl_width});
  assign ylim = $signed({1'b0, cfg.y_end}) - $signed({2'b0, cfg.tmpl_height});
  assign xlim_w = xlim[7:0];
  assign ylim_w = ylim[7:0];

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{8'd128, 8'd128, 7'd11, 7'd13, 7'd0, 8'd128, 7'd0, 8'd128};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_e'(cfg_index))
        CFG_SRC_W:  cfg.src_width   <= cfg_data;
        CFG_SRC_H:  cfg.src_height  <= cfg_data;
        CFG_TMPL_W: cfg.tmpl_width  <= cfg_data[6:0];
        CFG_TMPL_H: cfg.tmpl_height <= cfg_data[6:0];
        CFG_X0:     cfg.x_start     <= cfg_data[6:0];
        CFG_X1:     cfg.x_end       <= cfg_data;
        CFG_Y0:     cfg.y_start     <= cfg_data[6:0];
        CFG_Y1:     cfg.y_end       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ta = trow + {5'b0, mx};
  assign fa = trow + {5'b0, cfg.tmpl_width - 7'd1 - mx};
  assign sa = srow + {6'b0, px} + {7'b0, mx};

  mss_mem #(.Aw(TmplAw), .Dw(25)) u_tmpl (
    .clk, .we(accept_in && in_data.req_type == REQ_TMPL && in_data.pixel_index[13:12] == 2'b0),
    .waddr(in_data.pixel_index[11:0]),
    .wdata({in_data.counted, in_data.red, in_data.green, in_data.blue}),
    .raddr(ta), .rdata(t_rd)
  );
  mss_mem #(.Aw(TmplAw), .Dw(25)) u_tmplf (
    .clk, .we(accept_in && in_data.req_type == REQ_TMPL && in_data.pixel_index[13:12] == 2'b0),
    .waddr(in_data.pixel_index[11:0]),
    .wdata({in_data.counted, in_data.red, in_data.green, in_data.blue}),
    .raddr(fa), .rdata(f_rd)
  );
  mss_mem #(.Aw(SrcAw), .Dw(24)) u_src (
    .clk, .we(accept_in && in_data.req_type == REQ_SRC),
    .waddr(in_data.pixel_index),
    .wdata({in_data.red, in_data.green, in_data.blue}),
    .raddr(sa), .rdata(s_rd)
  );

  mss_div u_div (
    .clk, .rst, .start(div_start),
    .dividend(best), .divisor({7'b0, cfg.tmpl_width} * {7'b0, cfg.tmpl_height}),
    .busy(div_busy), .quotient(quo)
  );

  assign last_mx = (mx == cfg.tmpl_width - 7'd1);
  assign last_my = (my == cfg.tmpl_height - 7'd1);
  assign last_x  = ($signed({1'b0, px + 8'd1}) >= xlim);
  assign last_y  = ($signed({1'b0, py + 8'd1}) >= ylim);
  assign take_s  = !have || (sum < best);
  assign cand    = take_s ? sum : best;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept_in && in_data.req_type == REQ_SEARCH) begin
          if ($signed({2'b0, cfg.y_start}) < ylim && $signed({2'b0, cfg.x_start}) < xlim
              && cfg.tmpl_width != 7'd0 && cfg.tmpl_height != 7'd0) begin
            state_next = ST_PIX;
          end else if ($signed({2'b0, cfg.y_start}) < ylim
                       && $signed({2'b0, cfg.x_start}) < xlim) begin
            state_next = ST_CMP;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_POS: state_next = ST_PIX;
      ST_PIX: if (last_mx && last_my) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_CMP;
      ST_CMP: begin
        if (last_x && last_y) begin
          state_next = ST_DIV;
        end else begin
          state_next = (cfg.tmpl_width != 7'd0 && cfg.tmpl_height != 7'd0) ? ST_POS : ST_CMP;
        end
      end
      ST_DIV: begin
        if (!div_busy && !vld1) state_next = ST_OUT;
        div_start = vld1;
      end
      ST_OUT: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      vld1      <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      vld1 <= (state == ST_CMP) && (state_next == ST_DIV);
    end
  end

  always_ff @(posedge clk) begin
    msk1  <= (state == ST_PIX);
    mskf1 <= (state == ST_PIX);
    unique case (state)
      ST_IDLE: begin
        px <= {1'b0, cfg.x_start};
        py <= {1'b0, cfg.y_start};
        mx <= '0; my <= '0; trow <= '0;
        srow <= 14'({7'b0, cfg.y_start} * {6'b0, cfg.src_width});
        sum <= '0; sumf <= '0; have <= 1'b0; best <= '0; bx <= '0; by <= '0;
      end
      ST_POS: begin
        sum <= '0; sumf <= '0;
      end
      ST_PIX: begin
        if (last_mx) begin
          mx   <= '0;
          my   <= my + 7'd1;
          trow <= trow + {5'b0, cfg.tmpl_width};
          srow <= srow + {6'b0, cfg.src_width};
        end else begin
          mx <= mx + 7'd1;
        end
      end
      ST_CMP: begin
        have <= 1'b1;
        if (sumf < cand) best <= sumf; else best <= cand;
        if (take_s || sumf < cand) begin
          bx <= px[6:0]; by <= py[6:0];
        end
        sum <= '0; sumf <= '0;
        mx <= '0; my <= '0; trow <= '0;
        if (last_x) begin
          px   <= {1'b0, cfg.x_start};
          py   <= py + 8'd1;
          srow <= 14'({6'b0, py + 8'd1} * {6'b0, cfg.src_width});
        end else begin
          px   <= px + 8'd1;
          srow <= 14'({6'b0, py} * {6'b0, cfg.src_width});
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data.best_x     <= have ? bx : 7'd0;
          out_data.best_y     <= have ? by : 7'd0;
          out_data.difference <= (have && cfg.tmpl_width != 7'd0 && cfg.tmpl_height != 7'd0)
                                 ? quo[9:0] : 10'd0;
          out_data.found      <= have;
        end
      end
      default: ;
    endcase
    if (msk1 && t_rd[24]) sum  <= sum  + {14'b0, rgb_sad(s_rd, t_rd[23:0])};
    if (mskf1 && f_rd[24]) sumf <= sumf + {14'b0, rgb_sad(s_rd, f_rd[23:0])};
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) state != ST_IDLE |-> !in_ready)
    else $error("request taken during search");
  assert property (@(posedge clk) disable iff (rst) div_busy |-> state == ST_DIV)
    else $error("divider running outside its phase");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  logic unused;
  assign unused = ^{cfg.src_height, xlim_w, ylim_w, quo[23:10]};
endmodule
